[rtl/accumulating_key_value_table_macros.svh]
// Assertion macros for the accumulating key/value table.
// Used by rtl/accumulating_key_value_table.sv; expects clk_i and rst_ni in scope.
`ifndef ACCUMULATING_KEY_VALUE_TABLE_MACROS_SVH
`define ACCUMULATING_KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AKVT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define AKVT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/akvt_pkg.sv]
// Types and codes for the accumulating key/value table.
// No dependencies; used by rtl/accumulating_key_value_table.sv.
package akvt_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic signed [31:0] SUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [63:0]        key;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_t;

endpackage

[rtl/accumulating_key_value_table.sv]
// Accumulating key/value table: sequencer, key/valid memory and sum memory.
// Depends on rtl/akvt_pkg.sv and rtl/accumulating_key_value_table_macros.svh.
//
// An item (insert/accumulate, erase or find) is accepted in the idle state.
// The key memory is then scanned one entry per cycle through a registered read
// and compare, stopping at the first matching entry. The execute state then
// updates the memories and registers the result; it waits there while the
// previous result is still to be taken. The block then returns to the idle
// state for the next item. The single read port of the key memory sets the
// scan rate. After reset the block clears the valid bits held in every entry
// of the key memory before it accepts its first item. One result item comes
// back for every input item. The result register lets the next item be
// accepted while a result still waits.
module accumulating_key_value_table #(
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  akvt_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output akvt_pkg::out_t  out_o
);

`include "accumulating_key_value_table_macros.svh"

  localparam int unsigned IDXW = $clog2(ENTRIES);
  localparam int unsigned CNTW = $clog2(ENTRIES + 1);
  localparam logic [CNTW-1:0] CNT_END = CNTW'(ENTRIES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;

  logic [2:0] state_q, state_d;

  akvt_pkg::in_t item_q;
  logic [KEY_BITS-1:0] item_key;

  logic [CNTW-1:0] scan_q;
  logic            rd_en;
  logic            rd_vld_q;
  logic [IDXW-1:0] rd_idx_q;

  // Key memory entries carry the valid bit on top.
  logic [KEY_BITS:0]  key_mem [ENTRIES];
  logic signed [31:0] sum_mem [ENTRIES];
  logic [KEY_BITS:0]  key_rd_q;
  logic signed [31:0] sum_rd_q;

  logic               kw_en;
  logic [IDXW-1:0]    kw_addr;
  logic [KEY_BITS:0]  kw_data;
  logic               sw_en;
  logic [IDXW-1:0]    sw_addr;
  logic signed [31:0] sw_data;

  logic               hit_q;
  logic [IDXW-1:0]    hit_idx_q;
  logic signed [31:0] hit_sum_q;
  logic               free_q;
  logic [IDXW-1:0]    free_idx_q;

  logic               scan_done;
  logic               out_load;
  logic               out_valid_q;
  akvt_pkg::out_t     out_q;
  logic signed [31:0] res_value;
  logic [1:0]         res_status;

  logic signed [32:0] acc_sum;
  logic signed [31:0] acc_sat;

  assign item_key   = item_q.key[KEY_BITS-1:0];
  assign in_ready_o = (state_q == S_IDLE);
  assign rd_en      = (state_q == S_SCAN) && (scan_q != CNT_END) && !hit_q;
  assign scan_done  = hit_q || ((scan_q == CNT_END) && !rd_vld_q);
  assign out_load   = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  // Saturating adder for accumulate.
  assign acc_sum = {hit_sum_q[31], hit_sum_q} + {item_q.value[31], item_q.value};
  always_comb begin
    if (acc_sum[32] != acc_sum[31]) begin
      acc_sat = acc_sum[32] ? akvt_pkg::SUM_MIN : akvt_pkg::SUM_MAX;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (scan_q == CNT_END - 1'b1) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN:  if (scan_done) state_d = S_EXEC;
      S_EXEC:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (state_q == S_CLEAR) begin
        scan_q <= (state_d == S_IDLE) ? '0 : scan_q + 1'b1;
      end else if (state_q == S_IDLE) begin
        scan_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        if (rd_en) scan_q <= scan_q + 1'b1;
        if (rd_vld_q && !hit_q) begin
          if (key_rd_q[KEY_BITS] && (key_rd_q[KEY_BITS-1:0] == item_key)) begin
            hit_q <= 1'b1;
          end else if (!key_rd_q[KEY_BITS] && !free_q) begin
            free_q <= 1'b1;
          end
        end
      end
    end
  end

  // Item latch and scan payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_i;
    if (rd_en) rd_idx_q <= scan_q[IDXW-1:0];
    if ((state_q == S_SCAN) && rd_vld_q && !hit_q) begin
      if (key_rd_q[KEY_BITS] && (key_rd_q[KEY_BITS-1:0] == item_key)) begin
        hit_idx_q <= rd_idx_q;
        hit_sum_q <= sum_rd_q;
      end else if (!key_rd_q[KEY_BITS] && !free_q) begin
        free_idx_q <= rd_idx_q;
      end
    end
  end

  // Update and result.
  always_comb begin
    kw_en      = 1'b0;
    kw_addr    = scan_q[IDXW-1:0];
    kw_data    = '0;
    sw_en      = 1'b0;
    sw_addr    = hit_idx_q;
    sw_data    = acc_sat;
    res_value  = '0;
    res_status = akvt_pkg::ST_OK;
    if (state_q == S_CLEAR) begin
      kw_en = 1'b1;
    end else if (state_q == S_EXEC) begin
      case (item_q.cmd)
        akvt_pkg::CMD_INSERT: begin
          if (hit_q) begin
            sw_en = 1'b1;
          end else if (free_q) begin
            kw_en   = 1'b1;
            kw_addr = free_idx_q;
            kw_data = {1'b1, item_key};
            sw_en   = 1'b1;
            sw_addr = free_idx_q;
            sw_data = item_q.value;
          end else begin
            res_status = akvt_pkg::ST_FULL;
          end
        end
        akvt_pkg::CMD_ERASE: begin
          if (hit_q) begin
            kw_en   = 1'b1;
            kw_addr = hit_idx_q;
            kw_data = {1'b0, item_key};
          end else begin
            res_status = akvt_pkg::ST_NOT_FOUND;
          end
        end
        akvt_pkg::CMD_FIND: begin
          if (hit_q) res_value = hit_sum_q;
          else res_status = akvt_pkg::ST_NOT_FOUND;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (kw_en) key_mem[kw_addr] <= kw_data;
    if (rd_en) key_rd_q <= key_mem[scan_q[IDXW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (sw_en) sum_mem[sw_addr] <= sw_data;
    if (rd_en) sum_rd_q <= sum_mem[scan_q[IDXW-1:0]];
  end

  // Result register; hold until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.result_value <= res_value;
      out_q.status       <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `AKVT_ASSERT_NXT(a_accept_scan, in_valid_i && in_ready_o, state_q == S_SCAN,
                   "accepted item did not start a scan")
  `AKVT_ASSERT_IMP(a_scan_bound, state_q == S_SCAN, scan_q <= CNT_END,
                   "scan counter ran past the table")
  `AKVT_ASSERT_IMP(a_full_cause, state_q == S_EXEC && res_status == akvt_pkg::ST_FULL,
                   item_q.cmd == akvt_pkg::CMD_INSERT && !hit_q && !free_q,
                   "table full reported with a free or matching entry")
  `AKVT_ASSERT_IMP(a_clear_quiet, state_q == S_CLEAR, !out_valid_q && !in_ready_o,
                   "item traffic during clearing pass")

endmodule
